/* rtl/pbst_pkg.sv */
// Shared types, codes and defaults for the pooled binary search tree.
package pbst_pkg;

  localparam int unsigned POOL_SIZE_DEF = 16;
  localparam int unsigned KEY_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_DELETE  = 2'd1,
    CMD_DEL_MIN = 2'd2,
    CMD_DEL_MAX = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SEL_ONE_CHILD = 2'd0,
    SEL_OTHER     = 2'd1,
    SEL_NEW       = 2'd2
  } link_sel_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] key;
  } in_t;

  typedef struct packed {
    logic signed [31:0] removed_key;
    logic [1:0]         status;
  } out_t;

  typedef struct packed {
    logic      ld_in;
    logic      rd;
    logic      rd_fh;
    logic      step_find;
    logic      step_ext;
    logic      start_del_ext;
    logic      wr_link;
    link_sel_e sel;
    logic      wr_free;
    logic      wr_alloc;
    logic      wr_succ;
    logic      set_st;
    status_e   st;
    logic      load_out;
  } ctrl_t;

  typedef struct packed {
    logic in_is_ext;
    logic is_ins;
    logic cur_none;
    logic limit;
    logic key_eq;
    logic child_none;
    logic l_none;
    logic r_none;
    logic fh_none;
    logic del_mode;
    logic out_free;
  } stat_t;

endpackage

/* rtl/pooled_binary_search_tree.sv */
// Top level: binary search tree of signed keys in a fixed node pool.
// One command at a time; each tree level walked is one read of the node memories
// followed by one compare, and a two-child delete walks again for the successor.
// The result waits in an output register while the next command is taken.
// Reset is immediate: the free list is served by a watermark, so no clearing pass runs.
module pooled_binary_search_tree #(
  parameter int unsigned POOL_SIZE = pbst_pkg::POOL_SIZE_DEF,
  parameter int unsigned KEY_WIDTH = pbst_pkg::KEY_WIDTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  pbst_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output pbst_pkg::out_t out_data_o
);

  pbst_pkg::ctrl_t ctrl;
  pbst_pkg::stat_t stat;

  pbst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  pbst_datapath #(
    .POOL_SIZE (POOL_SIZE),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_data_o),
    .ctrl_i      (ctrl),
    .stat_o      (stat)
  );

endmodule

/* rtl/pbst_datapath.sv */
// Datapath of the pooled binary search tree: node memories, links, walk registers, result.
module pbst_datapath #(
  parameter int unsigned POOL_SIZE = pbst_pkg::POOL_SIZE_DEF,
  parameter int unsigned KEY_WIDTH = pbst_pkg::KEY_WIDTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pbst_pkg::in_t  in_i,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output pbst_pkg::out_t out_o,
  input  pbst_pkg::ctrl_t ctrl_i,
  output pbst_pkg::stat_t stat_o
);

  localparam int unsigned IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int unsigned LW = IW + 1;
  localparam logic [LW-1:0] NONE = '1;
  localparam logic [LW-1:0] POOL = LW'(POOL_SIZE);

  logic signed [KEY_WIDTH-1:0] key_mem [POOL_SIZE];
  logic [LW-1:0]               left_mem [POOL_SIZE];
  logic [LW-1:0]               right_mem [POOL_SIZE];

  logic [1:0]                  cmd_q;
  logic signed [KEY_WIDTH-1:0] k_q, key_rd_q, got_q;
  logic [LW-1:0]               l_rd_q, r_rd_q, r_eff;
  logic [IW-1:0]               rd_addr_q, rd_addr;
  logic [LW-1:0]               root_q, fh_q, wm_q, cur_q, steps_q;
  logic                        slot_root_q, slot_right_q, dir_left_q, del_mode_q;
  logic [IW-1:0]               slot_node_q, del_q, new_q;
  pbst_pkg::status_e           st_q;
  logic                        out_valid_q;
  pbst_pkg::out_t              out_q;
  logic [LW-1:0]               link_val;
  logic signed [63:0]          kx, gx;
  logic                        lt;

  assign kx = 64'(in_i.key);
  assign gx = 64'(got_q);
  assign lt = k_q < key_rd_q;
  assign rd_addr = ctrl_i.rd_fh ? fh_q[IW-1:0] : cur_q[IW-1:0];

  always_comb begin
    r_eff = r_rd_q;
    if (LW'(rd_addr_q) < wm_q) begin
      r_eff = (rd_addr_q == '0) ? NONE : LW'(rd_addr_q) - LW'(1);
    end
  end

  always_comb begin
    case (ctrl_i.sel)
      pbst_pkg::SEL_ONE_CHILD: link_val = (l_rd_q < POOL) ? l_rd_q : r_eff;
      pbst_pkg::SEL_OTHER:     link_val = dir_left_q ? r_eff : l_rd_q;
      pbst_pkg::SEL_NEW:       link_val = LW'(new_q);
      default:                 link_val = NONE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      key_rd_q  <= key_mem[rd_addr];
      l_rd_q    <= left_mem[rd_addr];
      r_rd_q    <= right_mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
    if (ctrl_i.wr_alloc) begin
      key_mem[fh_q[IW-1:0]] <= k_q;
    end else if (ctrl_i.wr_succ) begin
      key_mem[del_q] <= got_q;
    end
    if (ctrl_i.wr_alloc) begin
      left_mem[fh_q[IW-1:0]] <= NONE;
    end else if (ctrl_i.wr_link && !slot_root_q && !slot_right_q) begin
      left_mem[slot_node_q] <= link_val;
    end
    if (ctrl_i.wr_alloc) begin
      right_mem[fh_q[IW-1:0]] <= NONE;
    end else if (ctrl_i.wr_free) begin
      right_mem[cur_q[IW-1:0]] <= fh_q;
    end else if (ctrl_i.wr_link && !slot_root_q && slot_right_q) begin
      right_mem[slot_node_q] <= link_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_in) begin
      cmd_q        <= in_i.cmd;
      k_q          <= kx[KEY_WIDTH-1:0];
      cur_q        <= root_q;
      slot_root_q  <= 1'b1;
      slot_right_q <= 1'b0;
      steps_q      <= '0;
      dir_left_q   <= (in_i.cmd == pbst_pkg::CMD_DEL_MIN);
      del_mode_q   <= 1'b0;
    end else if (ctrl_i.step_find) begin
      slot_root_q  <= 1'b0;
      slot_node_q  <= cur_q[IW-1:0];
      slot_right_q <= !lt;
      cur_q        <= lt ? l_rd_q : r_eff;
      steps_q      <= steps_q + LW'(1);
    end else if (ctrl_i.step_ext) begin
      slot_root_q  <= 1'b0;
      slot_node_q  <= cur_q[IW-1:0];
      slot_right_q <= !dir_left_q;
      cur_q        <= dir_left_q ? l_rd_q : r_eff;
      steps_q      <= steps_q + LW'(1);
    end else if (ctrl_i.start_del_ext) begin
      del_q        <= cur_q[IW-1:0];
      del_mode_q   <= 1'b1;
      slot_root_q  <= 1'b0;
      slot_node_q  <= cur_q[IW-1:0];
      slot_right_q <= 1'b1;
      cur_q        <= r_eff;
      steps_q      <= '0;
      dir_left_q   <= 1'b1;
    end
    if (ctrl_i.wr_link && ctrl_i.sel == pbst_pkg::SEL_OTHER) begin
      got_q <= key_rd_q;
    end
    if (ctrl_i.wr_alloc) begin
      new_q <= fh_q[IW-1:0];
    end
    if (ctrl_i.set_st) begin
      st_q <= ctrl_i.st;
    end
    if (ctrl_i.load_out) begin
      out_q.status      <= st_q;
      out_q.removed_key <= (cmd_q[1] && st_q == pbst_pkg::ST_DONE) ? gx[31:0] : 32'sd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q      <= NONE;
      fh_q        <= LW'(POOL_SIZE - 1);
      wm_q        <= POOL;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.wr_link && slot_root_q) begin
        root_q <= link_val;
      end
      if (ctrl_i.wr_free) begin
        fh_q <= cur_q;
      end else if (ctrl_i.wr_alloc) begin
        fh_q <= (r_eff < POOL) ? r_eff : NONE;
        if (fh_q < wm_q) begin
          wm_q <= fh_q;
        end
      end
      if (ctrl_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.in_is_ext  = in_i.cmd[1];
  assign stat_o.is_ins     = (cmd_q == pbst_pkg::CMD_INSERT);
  assign stat_o.cur_none   = !(cur_q < POOL);
  assign stat_o.limit      = (steps_q == POOL);
  assign stat_o.key_eq     = (key_rd_q == k_q);
  assign stat_o.child_none = dir_left_q ? !(l_rd_q < POOL) : !(r_eff < POOL);
  assign stat_o.l_none     = !(l_rd_q < POOL);
  assign stat_o.r_none     = !(r_eff < POOL);
  assign stat_o.fh_none    = !(fh_q < POOL);
  assign stat_o.del_mode   = del_mode_q;
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

/* rtl/pbst_ctrl.sv */
// Controller state machine of the pooled binary search tree.
module pbst_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  pbst_pkg::stat_t stat_i,
  output pbst_pkg::ctrl_t ctrl_o
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_FIND  = 15'b000000000000010,
    S_FCMP  = 15'b000000000000100,
    S_FEND  = 15'b000000000001000,
    S_ALLOC = 15'b000000000010000,
    S_ALINK = 15'b000000000100000,
    S_DSEL  = 15'b000000001000000,
    S_DFREE = 15'b000000010000000,
    S_EXT   = 15'b000000100000000,
    S_XCMP  = 15'b000001000000000,
    S_XEND  = 15'b000010000000000,
    S_XLINK = 15'b000100000000000,
    S_XFREE = 15'b001000000000000,
    S_SUCC  = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    ctrl_o     = '0;
    ctrl_o.sel = pbst_pkg::SEL_ONE_CHILD;
    ctrl_o.st  = pbst_pkg::ST_DONE;
    state_d    = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.ld_in = 1'b1;
          state_d = stat_i.in_is_ext ? S_EXT : S_FIND;
        end
      end
      S_FIND: begin
        if (stat_i.cur_none || stat_i.limit) begin
          state_d = S_FEND;
        end else begin
          ctrl_o.rd = 1'b1;
          state_d = S_FCMP;
        end
      end
      S_FCMP: begin
        if (stat_i.key_eq) begin
          state_d = S_FEND;
        end else begin
          ctrl_o.step_find = 1'b1;
          state_d = S_FIND;
        end
      end
      S_FEND: begin
        if (stat_i.is_ins) begin
          if (!stat_i.cur_none) begin
            ctrl_o.set_st = 1'b1;
            ctrl_o.st = pbst_pkg::ST_MISS;
            state_d = S_OUT;
          end else if (stat_i.fh_none) begin
            ctrl_o.set_st = 1'b1;
            ctrl_o.st = pbst_pkg::ST_FULL;
            state_d = S_OUT;
          end else begin
            ctrl_o.rd = 1'b1;
            ctrl_o.rd_fh = 1'b1;
            state_d = S_ALLOC;
          end
        end else if (stat_i.cur_none) begin
          ctrl_o.set_st = 1'b1;
          ctrl_o.st = pbst_pkg::ST_MISS;
          state_d = S_OUT;
        end else begin
          ctrl_o.rd = 1'b1;
          state_d = S_DSEL;
        end
      end
      S_ALLOC: begin
        ctrl_o.wr_alloc = 1'b1;
        state_d = S_ALINK;
      end
      S_ALINK: begin
        ctrl_o.wr_link = 1'b1;
        ctrl_o.sel = pbst_pkg::SEL_NEW;
        ctrl_o.set_st = 1'b1;
        state_d = S_OUT;
      end
      S_DSEL: begin
        if (stat_i.l_none || stat_i.r_none) begin
          ctrl_o.wr_link = 1'b1;
          ctrl_o.sel = pbst_pkg::SEL_ONE_CHILD;
          state_d = S_DFREE;
        end else begin
          ctrl_o.start_del_ext = 1'b1;
          state_d = S_EXT;
        end
      end
      S_DFREE: begin
        ctrl_o.wr_free = 1'b1;
        ctrl_o.set_st = 1'b1;
        state_d = S_OUT;
      end
      S_EXT: begin
        if (stat_i.cur_none || stat_i.limit) begin
          state_d = S_XEND;
        end else begin
          ctrl_o.rd = 1'b1;
          state_d = S_XCMP;
        end
      end
      S_XCMP: begin
        if (stat_i.child_none) begin
          state_d = S_XEND;
        end else begin
          ctrl_o.step_ext = 1'b1;
          state_d = S_EXT;
        end
      end
      S_XEND: begin
        if (stat_i.cur_none) begin
          ctrl_o.set_st = 1'b1;
          ctrl_o.st = stat_i.del_mode ? pbst_pkg::ST_DONE : pbst_pkg::ST_EMPTY;
          state_d = S_OUT;
        end else begin
          ctrl_o.rd = 1'b1;
          state_d = S_XLINK;
        end
      end
      S_XLINK: begin
        ctrl_o.wr_link = 1'b1;
        ctrl_o.sel = pbst_pkg::SEL_OTHER;
        state_d = S_XFREE;
      end
      S_XFREE: begin
        ctrl_o.wr_free = 1'b1;
        if (stat_i.del_mode) begin
          state_d = S_SUCC;
        end else begin
          ctrl_o.set_st = 1'b1;
          state_d = S_OUT;
        end
      end
      S_SUCC: begin
        ctrl_o.wr_succ = 1'b1;
        ctrl_o.set_st = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          ctrl_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
